FILE: rtl/core/smix_pkg.sv
// Shared types, constants and helper functions for the sample playback mixer.
// No dependencies; imported by every module of the block but smix_ram.
package smix_pkg;

  localparam int VOICES       = 16;
  localparam int VOICE_W      = $clog2(VOICES);
  localparam int SAMPLE_WORDS = 65536;
  localparam int ADDR_W       = $clog2(SAMPLE_WORDS);
  localparam int PHASE_W      = 34;
  localparam int LEN_W        = 17;
  localparam int STEP_W       = 24;
  localparam int ACC_W        = 54;
  localparam int PADDR_W      = 2;

  localparam logic [PADDR_W-1:0] REG_MASTER     = 2'd0;
  localparam logic [15:0]        MASTER_RESET   = 16'h8000;
  localparam logic [15:0]        STEREO_GAIN    = 16'h8000;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_START = 2'd2,
    OP_STOP  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK,
    ST_RD1,
    ST_RD2,
    ST_MUL,
    ST_ACC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic chk;
    logic rd1;
    logic rd2;
    logic mul;
    logic acc_en;
    logic next_voice;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic last;
    logic out_free;
    logic master_zero;
  } status_t;

  // Rounded phase index, clamped to length-1 (zero length clamps to zero).
  function automatic logic [ADDR_W-1:0] clamp_index(input logic [PHASE_W-1:0] phase,
                                                    input logic [LEN_W-1:0] len);
    logic [PHASE_W:0]      sum;
    logic [PHASE_W-16:0]   idx;
    logic [LEN_W-1:0]      top;
    logic [LEN_W-1:0]      sel;
    sum = {1'b0, phase} + (PHASE_W+1)'(32768);
    idx = sum[PHASE_W:16];
    top = (len == '0) ? '0 : len - LEN_W'(1);
    sel = (idx > (PHASE_W-15)'(top)) ? top : idx[LEN_W-1:0];
    return sel[ADDR_W-1:0];
  endfunction

  // Divide by 2^31, round half up, saturate to 16 bits.
  function automatic logic signed [15:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W:0]     t;
    logic signed [ACC_W-31:0]  q;
    t = {acc[ACC_W-1], acc} + (ACC_W+1)'(64'h4000_0000);
    q = (ACC_W-30)'(t >>> 31);
    if (q > (ACC_W-30)'(32767))       return 16'sh7fff;
    else if (q < -(ACC_W-30)'(32768)) return 16'sh8000;
    else                               return q[15:0];
  endfunction

endpackage

FILE: rtl/core/smix_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module smix_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/smix_ctrl.sv
// Controller state machine for the mixer: sequences the per-voice walk.
// Depends on smix_pkg.
module smix_ctrl
  import smix_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic [1:0] in_op,
  input  status_t stat,
  output logic    in_stall,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (op_t'(in_op))
            OP_TICK:  state_next = stat.master_zero ? ST_EMIT : ST_CHK;
            OP_START: state_next = ST_EMIT;
            OP_WRITE,
            OP_STOP:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_CHK: begin
        if (stat.skip) state_next = stat.last ? ST_EMIT : ST_CHK;
        else           state_next = ST_RD1;
      end
      ST_RD1:  state_next = ST_RD2;
      ST_RD2:  state_next = ST_MUL;
      ST_MUL:  state_next = ST_ACC;
      ST_ACC:  state_next = stat.last ? ST_EMIT : ST_CHK;
      ST_EMIT: if (stat.out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: cmd.accept = in_valid;
      ST_CHK: begin
        cmd.chk        = 1'b1;
        cmd.next_voice = stat.skip;
      end
      ST_RD1: cmd.rd1 = 1'b1;
      ST_RD2: cmd.rd2 = 1'b1;
      ST_MUL: cmd.mul = 1'b1;
      ST_ACC: begin
        cmd.acc_en     = 1'b1;
        cmd.next_voice = 1'b1;
      end
      ST_EMIT: cmd.load_out = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

FILE: rtl/core/smix_dp.sv
// Datapath for the mixer: voice state, sample memory, multiply-accumulate, output register.
// Depends on smix_pkg and smix_ram.
module smix_dp
  import smix_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  cmd_t                      cmd,
  output status_t                   stat,
  input  logic [15:0]               master,
  input  logic [1:0]                op,
  input  logic [ADDR_W-1:0]         address,
  input  logic signed [15:0]        sample_left,
  input  logic signed [15:0]        sample_right,
  input  logic [VOICE_W-1:0]        voice,
  input  logic [LEN_W-1:0]          length,
  input  logic [STEP_W-1:0]         step,
  input  logic [15:0]               gain_left,
  input  logic [15:0]               gain_right,
  input  logic                      stereo,
  input  logic                      loop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      kind,
  output logic signed [15:0]        mix_left,
  output logic signed [15:0]        mix_right,
  output logic [VOICE_W-1:0]        voice_given,
  output logic                      no_free_voice
);

  logic [VOICES-1:0]        active;
  logic [VOICES-1:0]        loops;
  logic [VOICES-1:0]        is_stereo;
  logic [ADDR_W-1:0]        base   [VOICES];
  logic [LEN_W-1:0]         len    [VOICES];
  logic [PHASE_W-1:0]       phase  [VOICES];
  logic [STEP_W-1:0]        vstep  [VOICES];
  logic [15:0]              gl     [VOICES];
  logic [15:0]              gr     [VOICES];
  logic [VOICE_W-1:0]       last_started;

  logic [VOICE_W-1:0]       cnt;
  logic [31:0]              gm_l, gm_r;
  logic [31:0]              w0;
  logic signed [16:0]       s_l, s_r;
  logic signed [49:0]       p_l, p_r;
  logic signed [ACC_W-1:0]  acc_l, acc_r;
  logic                     res_kind;
  logic [VOICE_W-1:0]       res_voice;
  logic                     res_nofree;

  logic                     over;
  logic [PHASE_W-1:0]       pe;
  logic [ADDR_W-1:0]        raddr;
  logic [31:0]              rdata;
  logic                     found;
  logic [VOICE_W-1:0]       free_id;
  logic [VOICE_W-1:0]       cand;
  logic                     is_op_start, is_op_stop, is_op_write, is_op_tick;

  assign is_op_tick  = cmd.accept && (op_t'(op) == OP_TICK);
  assign is_op_write = cmd.accept && (op_t'(op) == OP_WRITE);
  assign is_op_start = cmd.accept && (op_t'(op) == OP_START);
  assign is_op_stop  = cmd.accept && (op_t'(op) == OP_STOP);

  // Phase past the end restarts (loop) or retires the voice.
  assign over = phase[cnt] > {1'b0, len[cnt], 16'b0};
  assign pe   = over ? '0 : phase[cnt];

  assign stat.skip        = !active[cnt] || (over && !loops[cnt]);
  assign stat.last        = (cnt == VOICE_W'(VOICES - 1));
  assign stat.out_free    = !out_valid || !out_stall;
  assign stat.master_zero = (master == '0);

  assign raddr = cmd.rd1 ? base[cnt] + clamp_index(phase[cnt], len[cnt])
                         : base[cnt] + clamp_index(pe, len[cnt]);

  smix_ram #(.WIDTH(32), .DEPTH(SAMPLE_WORDS)) u_ram (
    .clk   (clk),
    .we    (is_op_write),
    .waddr (address),
    .wdata ({sample_right, sample_left}),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Round-robin search for a free voice, starting at the last one started.
  always_comb begin
    found   = 1'b0;
    free_id = '0;
    cand    = '0;
    for (int k = 0; k < VOICES; k++) begin
      cand = last_started + VOICE_W'(k);
      if (!found && !active[cand]) begin
        found   = 1'b1;
        free_id = cand;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= '0;
      last_started <= '0;
    end else begin
      if (is_op_stop) active[voice] <= 1'b0;
      if (is_op_start && found) begin
        active[free_id] <= 1'b1;
        last_started    <= free_id;
      end
      if (cmd.chk && active[cnt] && over && !loops[cnt]) active[cnt] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_op_start && found) begin
      loops[free_id]     <= loop;
      is_stereo[free_id] <= stereo;
      base[free_id]      <= address;
      len[free_id]       <= length;
      vstep[free_id]     <= step;
      gl[free_id]        <= gain_left;
      gr[free_id]        <= gain_right;
      phase[free_id]     <= '0;
    end
    if (cmd.chk && !stat.skip) begin
      phase[cnt] <= pe + PHASE_W'(vstep[cnt]);
      gm_l <= (is_stereo[cnt] ? STEREO_GAIN : gl[cnt]) * master;
      gm_r <= (is_stereo[cnt] ? STEREO_GAIN : gr[cnt]) * master;
    end
    if (cmd.rd1) w0 <= rdata;
    if (cmd.rd2) begin
      s_l <= 17'(signed'(w0[15:0])) + 17'(signed'(rdata[15:0]));
      s_r <= is_stereo[cnt]
             ? 17'(signed'(w0[31:16])) + 17'(signed'(rdata[31:16]))
             : 17'(signed'(w0[15:0])) + 17'(signed'(rdata[15:0]));
    end
    if (cmd.mul) begin
      p_l <= s_l * signed'({1'b0, gm_l});
      p_r <= s_r * signed'({1'b0, gm_r});
    end
    if (is_op_start) begin
      res_kind   <= 1'b1;
      res_voice  <= found ? free_id : '0;
      res_nofree <= !found;
    end
    if (is_op_tick) begin
      res_kind <= 1'b0;
      acc_l    <= '0;
      acc_r    <= '0;
    end else if (cmd.acc_en) begin
      acc_l <= acc_l + ACC_W'(p_l);
      acc_r <= acc_r + ACC_W'(p_r);
    end
    if (is_op_tick) begin
      cnt <= '0;
    end else if (cmd.next_voice) begin
      cnt <= cnt + VOICE_W'(1);
    end
    if (cmd.load_out) begin
      kind          <= res_kind;
      mix_left      <= res_kind ? '0 : round_sat(acc_l);
      mix_right     <= res_kind ? '0 : round_sat(acc_r);
      voice_given   <= res_kind ? res_voice : '0;
      no_free_voice <= res_kind ? res_nofree : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: rtl/core/sample_playback_voice_mixer_unit.sv
// Sample playback mixer top level. One item is in work at a time. Write and stop
// finish on acceptance; a start answers from the emit state; a tick walks all 16
// voices (none if master volume is zero): an idle voice is skipped, an active one
// takes check, two sample memory reads on the single read port, multiply, accumulate.
// Synchronous active-high reset clears voices, round-robin pointer and output valid;
// master volume resets to 0x8000. Sample memory is not cleared.
module sample_playback_voice_mixer_unit
  import smix_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           op,
  input  logic [15:0]          address,
  input  logic signed [15:0]   sample_left,
  input  logic signed [15:0]   sample_right,
  input  logic [3:0]           voice,
  input  logic [16:0]          length,
  input  logic [23:0]          step,
  input  logic [15:0]          gain_left,
  input  logic [15:0]          gain_right,
  input  logic                 stereo,
  input  logic                 loop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 kind,
  output logic signed [15:0]   mix_left,
  output logic signed [15:0]   mix_right,
  output logic [3:0]           voice_given,
  output logic                 no_free_voice
);

  logic [15:0] master_gain;
  cmd_t        cmd;
  status_t     stat;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_MASTER) ? {16'b0, master_gain} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      master_gain <= MASTER_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_MASTER) begin
      master_gain <= pwdata[15:0];
    end
  end

  smix_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_op    (op),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  smix_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .master        (master_gain),
    .op            (op),
    .address       (address),
    .sample_left   (sample_left),
    .sample_right  (sample_right),
    .voice         (voice),
    .length        (length),
    .step          (step),
    .gain_left     (gain_left),
    .gain_right    (gain_right),
    .stereo        (stereo),
    .loop          (loop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .mix_left      (mix_left),
    .mix_right     (mix_right),
    .voice_given   (voice_given),
    .no_free_voice (no_free_voice)
  );

`ifndef SYNTHESIS
  a_fail_no_voice: assert property (@(posedge clk) disable iff (rst)
    out_valid && no_free_voice |-> kind && voice_given == '0)
    else $error("failed start carries a voice number");
  a_frame_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kind |-> voice_given == '0 && !no_free_voice)
    else $error("frame carries start answer fields");
  a_start_silent: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind |-> mix_left == '0 && mix_right == '0)
    else $error("start answer carries mix data");
  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall && in_stall |=> in_stall || !out_valid || !out_stall)
    else $error("controller left emit with result held");
`endif

endmodule

FILE: test/sample_playback_voice_mixer_unit_checker.sv
// Checker for the sample playback mixer: watches both channels and the register port,
// keeps its own voice and sample state, and compares every frame and start answer.
// Depends on smix_pkg for the operation codes, register index, voice count and master reset.
module sample_playback_voice_mixer_unit_checker
  import smix_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         op,
  input  logic [15:0]        address,
  input  logic [15:0]        sample_left,
  input  logic [15:0]        sample_right,
  input  logic [3:0]         voice,
  input  logic [16:0]        length,
  input  logic [23:0]        step,
  input  logic [15:0]        gain_left,
  input  logic [15:0]        gain_right,
  input  logic               stereo,
  input  logic               loop,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               kind,
  input  logic [15:0]        mix_left,
  input  logic [15:0]        mix_right,
  input  logic [3:0]         voice_given,
  input  logic               no_free_voice,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic        kind;
    logic [15:0] left;
    logic [15:0] right;
    logic [3:0]  given;
    logic        full;
  } answer_t;

  answer_t     answers[$];
  logic [31:0] words[int];
  logic        v_on[VOICES];
  logic        v_loop[VOICES];
  logic        v_st[VOICES];
  logic [15:0] v_base[VOICES];
  logic [16:0] v_len[VOICES];
  logic [33:0] v_phase[VOICES];
  logic [23:0] v_step[VOICES];
  logic [15:0] v_gl[VOICES];
  logic [15:0] v_gr[VOICES];
  logic [3:0]  last_id;
  logic [15:0] master;

  assign pending = answers.size();

  function automatic logic [15:0] pick(logic [33:0] ph, logic [16:0] len);
    logic [34:0] ix;
    logic [16:0] top;
    ix  = ({1'b0, ph} + 35'd32768) >> 16;
    top = (len == 0) ? 17'd0 : len - 17'd1;
    return (ix > {18'd0, top}) ? top[15:0] : ix[15:0];
  endfunction

  function automatic logic [15:0] scale_down(longint acc);
    longint q;
    q = (acc + 64'sd1073741824) >>> 31;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic logic [31:0] fetch(logic [15:0] base, logic [15:0] ix);
    int a;
    a = int'(16'(base + ix));
    return words.exists(a) ? words[a] : 32'd0;
  endfunction

  function automatic answer_t mix_frame();
    answer_t     a;
    longint      accl, accr, sl, sr, gl, gr;
    logic [15:0] i0, i1;
    logic [31:0] w0, w1;
    a = '0;
    accl = 0;
    accr = 0;
    if (master != 0) begin
      for (int v = 0; v < VOICES; v++) begin
        if (!v_on[v]) continue;
        if (v_phase[v] > {1'b0, v_len[v], 16'd0}) begin
          if (v_loop[v]) v_phase[v] = '0;
          else begin
            v_on[v] = 1'b0;
            continue;
          end
        end
        i0 = pick(v_phase[v], v_len[v]);
        v_phase[v] = v_phase[v] + v_step[v];
        i1 = pick(v_phase[v], v_len[v]);
        w0 = fetch(v_base[v], i0);
        w1 = fetch(v_base[v], i1);
        sl = longint'($signed(w0[15:0])) + longint'($signed(w1[15:0]));
        if (v_st[v]) begin
          sr = longint'($signed(w0[31:16])) + longint'($signed(w1[31:16]));
          gl = 32768;
          gr = 32768;
        end else begin
          sr = sl;
          gl = v_gl[v];
          gr = v_gr[v];
        end
        accl += sl * gl * longint'(master);
        accr += sr * gr * longint'(master);
      end
      a.left  = scale_down(accl);
      a.right = scale_down(accr);
    end
    return a;
  endfunction

  function automatic answer_t claim_voice();
    answer_t    a;
    logic [3:0] id;
    a = '0;
    a.kind = 1'b1;
    for (int k = 0; k < VOICES; k++) begin
      id = last_id + 4'(k);
      if (v_on[id]) continue;
      v_on[id] = 1'b1;
      v_loop[id] = loop;
      v_st[id] = stereo;
      v_base[id] = address;
      v_len[id] = length;
      v_step[id] = step;
      v_gl[id] = gain_left;
      v_gr[id] = gain_right;
      v_phase[id] = '0;
      last_id = id;
      a.given = id;
      return a;
    end
    a.full = 1'b1;
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t got, want;
    if (rst) begin
      for (int v = 0; v < VOICES; v++) v_on[v] = 1'b0;
      last_id = '0;
      master = MASTER_RESET;
      answers.delete();
      errors = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_MASTER) master = pwdata[15:0];
      if (in_valid && !in_stall) begin
        case (op_t'(op))
          OP_WRITE: words[int'(address)] = {sample_right, sample_left};
          OP_STOP:  v_on[voice] = 1'b0;
          OP_START: answers.push_back(claim_voice());
          default:  answers.push_back(mix_frame());
        endcase
      end
      if (out_valid && !out_stall) begin
        got = '{kind, mix_left, mix_right, voice_given, no_free_voice};
        if (answers.size() == 0) begin
          $display("%0t: unexpected transfer %h", $time, got);
          errors++;
        end else begin
          want = answers.pop_front();
          if (got.kind != want.kind) begin
            $display("%0t: kind exp %0d got %0d", $time, want.kind, got.kind);
            errors++;
          end
          if (got.left != want.left) begin
            $display("%0t: mix_left exp %0d got %0d", $time,
                     $signed(want.left), $signed(got.left));
            errors++;
          end
          if (got.right != want.right) begin
            $display("%0t: mix_right exp %0d got %0d", $time,
                     $signed(want.right), $signed(got.right));
            errors++;
          end
          if (got.given != want.given) begin
            $display("%0t: voice_given exp %0d got %0d", $time, want.given, got.given);
            errors++;
          end
          if (got.full != want.full) begin
            $display("%0t: no_free_voice exp %0d got %0d", $time, want.full, got.full);
            errors++;
          end
        end
      end
    end
  end

endmodule

FILE: test/sample_playback_voice_mixer_unit_test.sv
// Stimulus and verdict for the sample playback mixer: fills sample memory, starts,
// stops and ticks voices under several master volumes. Depends on smix_pkg, the mixer and the checker.
module sample_playback_voice_mixer_unit_test;
  import smix_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0, in_stall;
  logic [1:0]         op = OP_TICK;
  logic [15:0]        address = '0, sample_left = '0, sample_right = '0;
  logic [3:0]         voice = '0;
  logic [16:0]        length = '0;
  logic [23:0]        step = '0;
  logic [15:0]        gain_left = '0, gain_right = '0;
  logic               stereo = 1'b0, loop = 1'b0;
  logic               out_valid, out_stall = 1'b0;
  logic               kind, no_free_voice;
  logic [15:0]        mix_left, mix_right;
  logic [3:0]         voice_given;
  int                 errors, pending, quiet;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sample_playback_voice_mixer_unit i_dut (.*);
  sample_playback_voice_mixer_unit_checker i_chk (.*);

  // receiver stall pattern: runs of stalls and runs of open cycles
  int stall_run = 0;
  always @(posedge clk) begin
    if (stall_run > 0) stall_run <= stall_run - 1;
    else begin
      out_stall <= ($urandom_range(0, 2) == 0);
      stall_run <= $urandom_range(0, 6);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("[sample_playback_voice_mixer_unit] ERROR");
      $finish;
    end
  end

  task automatic send(logic [1:0] o, logic [15:0] a, logic [15:0] sl, logic [15:0] sr,
                      logic [3:0] vc, logic [16:0] len, logic [23:0] st,
                      logic [15:0] gl, logic [15:0] gr, logic s, logic lp);
    in_valid <= 1'b1;
    op <= o; address <= a; sample_left <= sl; sample_right <= sr; voice <= vc;
    length <= len; step <= st; gain_left <= gl; gain_right <= gr; stereo <= s; loop <= lp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_master(logic [15:0] m);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= REG_MASTER; pwdata <= {16'd0, m};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic rand_start(logic [15:0] base, int span);
    logic [16:0] len;
    len = (span > 1) ? 17'($urandom_range(0, span)) : 17'(span);
    send(OP_START, base, '0, '0, '0, len,
         ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 3 << 16)),
         ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768)),
         ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768)),
         1'($urandom), 1'($urandom));
  endtask

  initial begin
    logic [15:0] masters[6];
    masters = '{16'h8000, 16'h0001, 16'hFFFF, 16'h0000, 16'h4000, 16'h8000};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // fill the whole memory region used by every start so no read hits an unwritten word
    for (int k = 0; k < 128; k++)
      send(OP_WRITE, 16'(k), 16'($urandom), 16'($urandom), '0, '0, '0, '0, '0,
           1'b0, 1'b0);
    for (int k = 65472; k < 65536; k++)
      send(OP_WRITE, 16'(k), (k[0]) ? 16'h8000 : 16'h7FFF, 16'h7FFF, '0, '0, '0, '0, '0,
           1'b0, 1'b0);
    // directed: extremes, zero length, zero step, wrap past top of memory
    send(OP_TICK, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0);
    send(OP_START, 16'd65472, '0, '0, '0, 17'd64, 24'hFFFFFF, 16'hFFFF, 16'h8000,
         1'b0, 1'b1);
    send(OP_START, 16'd65500, '0, '0, '0, 17'd100, 24'h010000, 16'h8000, 16'h0,
         1'b1, 1'b0);
    send(OP_START, 16'd0, '0, '0, '0, 17'd0, 24'd0, 16'h0, 16'hFFFF, 1'b0, 1'b0);
    send(OP_START, 16'd10, '0, '0, '0, 17'd1, 24'h008000, 16'h8000, 16'h8000, 1'b0, 1'b1);
    repeat (6) send(OP_TICK, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0);
    for (int k = 0; k < 14; k++)
      send(OP_START, 16'd65472, '0, '0, '0, 17'd64, 24'h020000, 16'h8000, 16'h8000,
           1'b1, 1'b1);
    send(OP_TICK, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0);
    send(OP_STOP, '0, '0, '0, 4'd15, '0, '0, '0, '0, 1'b0, 1'b0);
    send(OP_STOP, '0, '0, '0, 4'd15, '0, '0, '0, '0, 1'b0, 1'b0);
    send(OP_START, 16'd0, '0, '0, '0, 17'd64, 24'h000000, 16'h8000, 16'h8000, 1'b0, 1'b0);
    send(OP_TICK, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0);
    for (int v = 0; v < 16; v++)
      send(OP_STOP, '0, '0, '0, 4'(v), '0, '0, '0, '0, 1'b0, 1'b0);
    drain();
    // random phases, each under its own master volume
    for (int ph = 0; ph < 6; ph++) begin
      set_master(masters[ph]);
      for (int n = 0; n < 60; n++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: send(OP_TICK, 16'($urandom), 16'($urandom), 16'($urandom),
                              4'($urandom), 17'($urandom), 24'($urandom),
                              16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
          5, 6: begin
            if ($urandom_range(0, 1)) rand_start(16'($urandom_range(0, 63)), 64);
            else rand_start(16'($urandom_range(65472, 65535)), 64);
          end
          7: send(OP_STOP, 16'($urandom), '0, '0, 4'($urandom), '0, '0, '0, '0, 1'b0, 1'b0);
          8: send(OP_WRITE, 16'($urandom_range(0, 127)), 16'($urandom), 16'($urandom),
                   '0, '0, '0, '0, '0, 1'b0, 1'b0);
          default: send(OP_WRITE, 16'($urandom_range(65472, 65535)), 16'($urandom),
                        16'($urandom), '0, '0, '0, '0, '0, 1'b0, 1'b0);
        endcase
      end
      // hold until every expected transfer has arrived
      drain();
    end
    if (errors == 0) $display("[sample_playback_voice_mixer_unit] OK");
    else $display("[sample_playback_voice_mixer_unit] ERROR");
    $finish;
  end

endmodule

FILE: sample_playback_voice_mixer_unit.f
rtl/core/smix_pkg.sv
rtl/core/smix_ram.sv
rtl/core/smix_ctrl.sv
rtl/core/smix_dp.sv
rtl/core/sample_playback_voice_mixer_unit.sv
test/sample_playback_voice_mixer_unit_checker.sv
test/sample_playback_voice_mixer_unit_test.sv
